### design/u64da_pkg.sv
// ----------------------------------------------------------------------------
// u64da_pkg
// Shared constants and types for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u64da_pkg;

  // width of the converted number
  localparam int VALUE_WIDTH = 64;

  // decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

  // counter widths
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int REM_CNT_W = $clog2(NUM_DIGITS + 1);

  // digit coding
  localparam int BCD_W      = 4;
  localparam int CHAR_W     = 6;
  localparam int ASCII_ZERO = 48;

  // per-cycle command to every digit cell
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correction then shift one binary bit in
    logic shift;   // take the neighbor's digit (move digits toward the top)
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/u64da_cell.sv
// ----------------------------------------------------------------------------
// u64da_cell
// One BCD digit of the conversion chain: add-3 correction and bit shift
// during conversion, digit-wide shift during output.
// ----------------------------------------------------------------------------
`default_nettype none

module u64da_cell (
  input  wire logic                          clk,
  input  wire u64da_pkg::cell_ctrl_t         ctrl,
  input  wire logic                          bit_in,
  input  wire logic [u64da_pkg::BCD_W-1:0]   digit_in,
  output logic                               bit_out,
  output logic [u64da_pkg::BCD_W-1:0]        digit
);

  logic [u64da_pkg::BCD_W-1:0] digit_r;
  logic [u64da_pkg::BCD_W-1:0] digit_nxt;
  logic [u64da_pkg::BCD_W-1:0] adj;

  // add-3 correction before the shift
  always_comb begin
    if (digit_r >= 4'd5) begin
      adj = digit_r + 4'd3;
    end else begin
      adj = digit_r;
    end
  end

  assign bit_out = adj[u64da_pkg::BCD_W-1];
  assign digit   = digit_r;

  // next digit value
  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[u64da_pkg::BCD_W-2:0], bit_in};
    end else if (ctrl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire

### design/u64_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// u64_to_decimal_ascii_top
// Unsigned binary to decimal ASCII digits, most significant first, no
// leading zeros, last digit marked.
// ----------------------------------------------------------------------------
//   channel  | ports                                | per transaction
//   ---------+--------------------------------------+------------------------
//   input    | in_valid, in_stall, in_value         | one number
//   output   | out_valid, out_stall, out_digit_char | one ASCII digit
//            | out_last                             |
//
// the number is loaded, then all VALUE_WIDTH bits are shifted with add-3
// correction through the row of digit cells, then leading zeros are dropped,
// the block steps into the send phase and sends the digits (one per cycle)
// when the output is not stalled. output stalls extend the send phase cycle
// for cycle. in_stall stays high until the last digit has gone to the output
// register. synchronous active-low reset clears the control.
// ----------------------------------------------------------------------------
`default_nettype none

module u64_to_decimal_ascii_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_digit_char,
  output logic             out_last
);

  localparam int W  = u64da_pkg::VALUE_WIDTH;
  localparam int ND = u64da_pkg::NUM_DIGITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [W-1:0]                       value_r, value_nxt;
  logic [u64da_pkg::BIT_CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [u64da_pkg::REM_CNT_W-1:0]    rem_r, rem_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [u64da_pkg::CHAR_W-1:0]       out_char_r, out_char_nxt;
  logic                               out_last_r, out_last_nxt;

  u64da_pkg::cell_ctrl_t              ctrl;
  logic [ND-1:0]                      bit_out;
  logic [ND-1:0]                      bit_in;
  logic [u64da_pkg::BCD_W-1:0]        digits [ND];
  logic [u64da_pkg::BCD_W-1:0]        digit_in [ND];
  logic [u64da_pkg::BCD_W-1:0]        top_digit;

  logic in_acc;
  logic out_free;
  logic rem_one;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign top_digit = digits[ND-1];
  assign rem_one   = (rem_r == u64da_pkg::REM_CNT_W'(1));

  // row of digit cells
  for (genvar i = 0; i < ND; i++) begin : g_cell
    if (i == 0) begin : g_low
      assign bit_in[i]   = value_r[W-1];
      assign digit_in[i] = '0;
    end else begin : g_up
      assign bit_in[i]   = bit_out[i-1];
      assign digit_in[i] = digits[i-1];
    end

    u64da_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (bit_in[i]),
      .digit_in (digit_in[i]),
      .bit_out  (bit_out[i]),
      .digit    (digits[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    bit_cnt_nxt   = bit_cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          value_nxt   = in_value[W-1:0];
          bit_cnt_nxt = u64da_pkg::BIT_CNT_W'(W - 1);
          ctrl.clear  = 1'b1;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        value_nxt   = {value_r[W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - u64da_pkg::BIT_CNT_W'(1);
        if (bit_cnt_r == '0) begin
          rem_nxt   = u64da_pkg::REM_CNT_W'(ND);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_digit == '0 && !rem_one) begin
          ctrl.shift = 1'b1;
          rem_nxt    = rem_r - u64da_pkg::REM_CNT_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = u64da_pkg::CHAR_W'(u64da_pkg::ASCII_ZERO)
                          + {2'b00, top_digit};
          out_last_nxt  = rem_one;
          ctrl.shift    = 1'b1;
          rem_nxt       = rem_r - u64da_pkg::REM_CNT_W'(1);
          if (rem_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire
